// File: design/isotp_rx_pkg.sv
// Shared types, codes and limits for the ISO-TP receive reassembler.
// No dependencies; used by isotp_rx_decode and isotp_reassembler_rx.
package isotp_rx_pkg;

    // Message length limit and length field width
    localparam int LEN_W = 9;
    localparam logic [11:0] MAX_LEN = 12'd256;

    // Input item modes
    localparam logic [1:0] MODE_ARM   = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Receiver phase
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_WAIT    = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_FC      = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    // Closing result of a job
    localparam logic [1:0] FIN_NONE    = 2'd0;
    localparam logic [1:0] FIN_DONE    = 2'd1;
    localparam logic [1:0] FIN_TIMEOUT = 2'd2;

    // PCI frame types (high nibble of byte 0)
    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    // UDS response bytes
    localparam logic [7:0] RSP_NEG     = 8'h7F;
    localparam logic [7:0] RSP_POS_MIN = 8'h40;

    // Configuration register indexes
    localparam logic REG_RESPONSE_ID   = 1'b0;
    localparam logic REG_FRAME_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]       phase;
        logic [15:0]      elapsed;
        logic [15:0]      budget;
        logic [LEN_W-1:0] exp_len;
        logic [LEN_W-1:0] rcv_len;
        logic [7:0]       first;
        logic [7:0]       third;
    } t_state;

    // Everything one accepted item still has to emit
    typedef struct packed {
        logic [6:0][7:0]  data;
        logic [2:0]       nbytes;
        logic [7:0]       idx;
        logic             fc;
        logic [1:0]       fin;
        logic [LEN_W-1:0] len;
        logic             pos;
        logic [7:0]       nrc;
    } t_job;

endpackage

// File: design/isotp_rx_decode.sv
// Item decode: next receiver state and the job of results for one item.
// Depends on isotp_rx_pkg.
module isotp_rx_decode (
    input  logic [1:0]              i_mode,
    input  logic [15:0]             i_wait_budget,
    input  logic [10:0]             i_can_id,
    input  logic [7:0][7:0]         i_frame,
    input  logic [10:0]             i_response_id,
    input  logic [15:0]             i_frame_timeout,
    input  isotp_rx_pkg::t_state    i_state,
    output isotp_rx_pkg::t_state    o_state,
    output isotp_rx_pkg::t_job      o_job,
    output logic                    o_has_result
);

    always_comb begin
        isotp_rx_pkg::t_state               st;
        isotp_rx_pkg::t_job                 job;
        logic [3:0]                         ftype;
        logic [3:0]                         nib;
        logic [11:0]                        total12;
        logic [isotp_rx_pkg::LEN_W-1:0]     total;
        logic [isotp_rx_pkg::LEN_W-1:0]     rem;
        logic [isotp_rx_pkg::LEN_W-1:0]     base;
        logic [15:0]                        el_inc;
        logic                               id_hit;

        st      = i_state;
        job     = '0;
        ftype   = i_frame[0][7:4];
        nib     = i_frame[0][3:0];
        total12 = {nib, i_frame[1]};
        total   = (total12 > isotp_rx_pkg::MAX_LEN) ?
                  isotp_rx_pkg::MAX_LEN[isotp_rx_pkg::LEN_W-1:0] :
                  total12[isotp_rx_pkg::LEN_W-1:0];
        rem     = i_state.exp_len - i_state.rcv_len;
        base    = i_state.rcv_len;
        el_inc  = (i_state.elapsed != 16'hFFFF) ? i_state.elapsed + 16'd1 : i_state.elapsed;
        id_hit  = (i_can_id == i_response_id);

        unique case (i_mode)
            isotp_rx_pkg::MODE_ARM: begin
                st.budget  = i_wait_budget;
                st.elapsed = '0;
                st.exp_len = '0;
                st.rcv_len = '0;
                st.first   = '0;
                st.third   = '0;
                if (i_wait_budget == 16'd0) begin
                    st.phase = isotp_rx_pkg::PH_IDLE;
                    job.fin  = isotp_rx_pkg::FIN_TIMEOUT;
                end else begin
                    st.phase = isotp_rx_pkg::PH_WAIT;
                end
            end
            isotp_rx_pkg::MODE_TICK: begin
                if (i_state.phase == isotp_rx_pkg::PH_WAIT ||
                    i_state.phase == isotp_rx_pkg::PH_COLLECT) begin
                    st.elapsed = el_inc;
                    if (i_state.phase == isotp_rx_pkg::PH_WAIT && el_inc >= i_state.budget) begin
                        st.phase = isotp_rx_pkg::PH_IDLE;
                        job.fin  = isotp_rx_pkg::FIN_TIMEOUT;
                    end else if (i_state.phase == isotp_rx_pkg::PH_COLLECT &&
                                 el_inc >= i_frame_timeout) begin
                        st.phase = isotp_rx_pkg::PH_IDLE;
                        job.fin  = isotp_rx_pkg::FIN_DONE;
                    end
                end
            end
            isotp_rx_pkg::MODE_FRAME: begin
                if (id_hit && i_state.phase == isotp_rx_pkg::PH_WAIT) begin
                    if (ftype == isotp_rx_pkg::FT_SINGLE) begin
                        // length nibble clamped to one frame's worth
                        job.nbytes = nib[3] ? 3'd7 : nib[2:0];
                        job.data   = i_frame[7:1];
                        base       = '0;
                        st.rcv_len = {{(isotp_rx_pkg::LEN_W-3){1'b0}}, job.nbytes};
                        st.phase   = isotp_rx_pkg::PH_IDLE;
                        job.fin    = isotp_rx_pkg::FIN_DONE;
                    end else if (ftype == isotp_rx_pkg::FT_FIRST) begin
                        job.nbytes = (total < 9'd6) ? total[2:0] : 3'd6;
                        job.data   = {8'h00, i_frame[7:2]};
                        job.fc     = 1'b1;
                        base       = '0;
                        st.exp_len = total;
                        st.rcv_len = {{(isotp_rx_pkg::LEN_W-3){1'b0}}, job.nbytes};
                        st.elapsed = '0;
                        if (st.rcv_len >= total || i_frame_timeout == 16'd0) begin
                            st.phase = isotp_rx_pkg::PH_IDLE;
                            job.fin  = isotp_rx_pkg::FIN_DONE;
                        end else begin
                            st.phase = isotp_rx_pkg::PH_COLLECT;
                        end
                    end
                end else if (id_hit && i_state.phase == isotp_rx_pkg::PH_COLLECT &&
                             ftype == isotp_rx_pkg::FT_CONSEC) begin
                    job.nbytes = (rem < 9'd7) ? rem[2:0] : 3'd7;
                    job.data   = i_frame[7:1];
                    st.rcv_len = i_state.rcv_len +
                                 {{(isotp_rx_pkg::LEN_W-3){1'b0}}, job.nbytes};
                    if (st.rcv_len >= i_state.exp_len) begin
                        st.phase = isotp_rx_pkg::PH_IDLE;
                        job.fin  = isotp_rx_pkg::FIN_DONE;
                    end
                end
            end
            default: begin
                // unused mode: no effect
            end
        endcase

        // capture the first and third message bytes as they pass
        for (int k = 0; k < 7; k++) begin
            if (3'(k) < job.nbytes) begin
                if (base + isotp_rx_pkg::LEN_W'(k) == '0) st.first = job.data[k];
                if (base + isotp_rx_pkg::LEN_W'(k) == isotp_rx_pkg::LEN_W'(2))
                    st.third = job.data[k];
            end
        end

        job.idx = base[7:0];
        job.len = st.rcv_len;
        job.pos = (st.rcv_len != '0) && (st.first >= isotp_rx_pkg::RSP_POS_MIN) &&
                  (st.first < isotp_rx_pkg::RSP_NEG);
        job.nrc = (st.rcv_len >= isotp_rx_pkg::LEN_W'(3) && st.first == isotp_rx_pkg::RSP_NEG) ?
                  st.third : 8'h00;

        o_state      = st;
        o_job        = job;
        o_has_result = (job.nbytes != 3'd0) || job.fc || (job.fin != isotp_rx_pkg::FIN_NONE);
    end

endmodule

// File: design/isotp_reassembler_rx.sv
// ISO-TP receive reassembler, top level: state, job register, result register.
// Depends on isotp_rx_pkg and isotp_rx_decode.
// The first result of an item passes through the job register, then the result register.
// Throughput: an item producing k results (0..8) holds the input channel until its last
// result is out; the emitter sets the rate, one result per cycle unless i_ready stalls,
// from the single result register; items with at most one result go back to back.
// Reset (i_rst_n low, synchronous): idle, counters/valids cleared, config to defaults.
module isotp_reassembler_rx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_wait_budget,
    input  logic [10:0] i_can_id,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    input  logic [7:0]  i_byte4,
    input  logic [7:0]  i_byte5,
    input  logic [7:0]  i_byte6,
    input  logic [7:0]  i_byte7,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_byte_index,
    output logic [8:0]  o_message_length,
    output logic        o_positive,
    output logic [7:0]  o_neg_code,
    output logic        o_last
);

    // Configuration registers
    logic [10:0] r_resp_id;
    logic [15:0] r_ftimeout;

    // Receiver state, updated on every input transfer
    isotp_rx_pkg::t_state r_state;
    isotp_rx_pkg::t_state n_state;

    // Job register: results still owed for the item last taken in
    logic               r_job_valid;
    isotp_rx_pkg::t_job r_job;
    isotp_rx_pkg::t_job n_job;
    isotp_rx_pkg::t_job dec_job;
    logic               dec_has_result;

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_pbyte;
    logic [7:0]  r_idx;
    logic [8:0]  r_len;
    logic        r_pos;
    logic [7:0]  r_nrc;
    logic        r_last;

    // Emitter signals
    logic        out_free;
    logic        job_step;
    logic        in_xfer;
    logic [1:0]  e_kind;
    logic        e_last;

    isotp_rx_decode u_decode (
        .i_mode          (i_mode),
        .i_wait_budget   (i_wait_budget),
        .i_can_id        (i_can_id),
        .i_frame         ({i_byte7, i_byte6, i_byte5, i_byte4,
                           i_byte3, i_byte2, i_byte1, i_byte0}),
        .i_response_id   (r_resp_id),
        .i_frame_timeout (r_ftimeout),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_job           (dec_job),
        .o_has_result    (dec_has_result)
    );

    // Emitter: payload bytes first, then flow control, then the closing result
    always_comb begin
        n_job = r_job;
        if (r_job.nbytes != 3'd0) begin
            e_kind       = isotp_rx_pkg::KIND_BYTE;
            e_last       = (r_job.nbytes == 3'd1) && !r_job.fc &&
                           (r_job.fin == isotp_rx_pkg::FIN_NONE);
            n_job.data   = {8'h00, r_job.data[6:1]};
            n_job.nbytes = r_job.nbytes - 3'd1;
            n_job.idx    = r_job.idx + 8'd1;
        end else if (r_job.fc) begin
            e_kind   = isotp_rx_pkg::KIND_FC;
            e_last   = (r_job.fin == isotp_rx_pkg::FIN_NONE);
            n_job.fc = 1'b0;
        end else begin
            e_kind = (r_job.fin == isotp_rx_pkg::FIN_TIMEOUT) ?
                     isotp_rx_pkg::KIND_TIMEOUT : isotp_rx_pkg::KIND_DONE;
            e_last = 1'b1;
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign job_step = r_job_valid && out_free;
    // take a new item once the job in hand hands over its final result
    assign o_ready  = !r_job_valid || (job_step && e_last);
    assign in_xfer  = i_valid && o_ready;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_id  <= 11'd1577;
            r_ftimeout <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                isotp_rx_pkg::REG_RESPONSE_ID:   r_resp_id  <= i_cfg_data[10:0];
                isotp_rx_pkg::REG_FRAME_TIMEOUT: r_ftimeout <= i_cfg_data;
                default:                         r_ftimeout <= r_ftimeout;
            endcase
        end
    end

    // Receiver state; all-zero is the idle phase with counters cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (in_xfer) begin
            r_job_valid <= dec_has_result;
        end else if (job_step && e_last) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_job <= dec_job;
        end else if (job_step) begin
            r_job <= n_job;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (job_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_step) begin
            r_kind  <= e_kind;
            r_last  <= e_last;
            r_pbyte <= (e_kind == isotp_rx_pkg::KIND_BYTE) ? r_job.data[0] : 8'h00;
            r_idx   <= (e_kind == isotp_rx_pkg::KIND_BYTE) ? r_job.idx : 8'h00;
            r_len   <= (e_kind == isotp_rx_pkg::KIND_DONE) ? r_job.len[8:0] : 9'd0;
            r_pos   <= (e_kind == isotp_rx_pkg::KIND_DONE) && r_job.pos;
            r_nrc   <= (e_kind == isotp_rx_pkg::KIND_DONE) ? r_job.nrc : 8'h00;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_pbyte;
    assign o_byte_index     = r_idx;
    assign o_message_length = r_len;
    assign o_positive       = r_pos;
    assign o_neg_code       = r_nrc;
    assign o_last           = r_last;

    // A held job always owes at least one result
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job.nbytes != 3'd0 || r_job.fc ||
                         r_job.fin != isotp_rx_pkg::FIN_NONE))
        else $error("job register holds no result");

    // Collecting only while the message is still short
    a_collect_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == isotp_rx_pkg::PH_COLLECT) |-> (r_state.rcv_len < r_state.exp_len))
        else $error("collecting with message already full");

    // Completion and timeout always close the transfer sequence of an item
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == isotp_rx_pkg::KIND_DONE ||
                         r_kind == isotp_rx_pkg::KIND_TIMEOUT)) |-> r_last)
        else $error("closing result not marked last");

    // No new item while the current job still owes more than its final result
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && !(out_free && e_last)) |-> !o_ready)
        else $error("input taken with results outstanding");

endmodule
